// ===== design/fva_pkg.sv =====
`timescale 1ns / 1ps
package fva_pkg;

   // widths and pipeline depths
   localparam int HALF_W    = 16;
   localparam int VEC_W     = 64;
   localparam int MAX_LANES = 4;
   localparam int DIV_STEPS = 14;
   localparam int LANE_LAT  = DIV_STEPS + 4;
   localparam int ALU_LAT   = LANE_LAT + 1;

   // binary16 codes
   localparam logic [15:0] QNAN16  = 16'h7E00;
   localparam logic [14:0] INF_MAG = 15'h7C00;
   localparam logic [14:0] ZERO_MAG = 15'h0000;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_RELU = 3'd4
   } op_type;

   // unpacked operand, significand normalized so bit 10 is set when nonzero
   typedef struct packed {
      logic              sign;
      logic              zero;
      logic              inf;
      logic              nan;
      logic signed [7:0] exp;
      logic [10:0]       sig;
   } half_type;

   typedef struct packed {
      op_type      op;
      logic        special;
      logic [15:0] sp_val;
      half_type    ua;
      half_type    ub;
   } front_type;

   // value is mag * 2^exp; divide steps work on rem, dvs and quo
   typedef struct packed {
      logic              special;
      logic [15:0]       sp_val;
      logic              is_div;
      logic              sign;
      logic signed [7:0] exp;
      logic [21:0]       mag;
      logic [11:0]       rem;
      logic [10:0]       dvs;
      logic [13:0]       quo;
   } lane_stage_type;

   typedef struct packed {
      logic              special;
      logic [15:0]       sp_val;
      logic              zero;
      logic              sign;
      logic signed [8:0] exp;
      logic [11:0]       quo;
      logic              guard;
      logic              sticky;
   } round_type;

endpackage

// ===== design/fva_div_stage.sv =====
`timescale 1ns / 1ps
module fva_div_stage import fva_pkg::*; (
   input  logic           clock,
   input  lane_stage_type stage_i,
   output lane_stage_type stage_o
);

   lane_stage_type stage_in;
   lane_stage_type stage_ff;
   logic           take;
   logic [11:0]    diff;

   // one restoring quotient bit per stage, other work passes along
   always_comb begin
      stage_in = stage_i;
      take     = stage_i.rem >= {1'b0, stage_i.dvs};
      diff     = take ? stage_i.rem - {1'b0, stage_i.dvs} : stage_i.rem;
      if (stage_i.is_div) begin
         stage_in.quo = {stage_i.quo[12:0], take};
         stage_in.rem = {diff[10:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage_o = stage_ff;

endmodule

// ===== design/fva_lane.sv =====
`timescale 1ns / 1ps
module fva_lane import fva_pkg::*; (
   input  logic        clock,
   input  op_type      op,
   input  logic [15:0] a,
   input  logic [15:0] b,
   output logic [15:0] result
);

   function automatic half_type unpack_half(input logic [15:0] h);
      half_type          u;
      logic [10:0]       raw;
      logic [3:0]        lz;
      logic signed [7:0] e0;
      u.sign = h[15];
      u.nan  = (&h[14:10]) && (|h[9:0]);
      u.inf  = (&h[14:10]) && !(|h[9:0]);
      u.zero = (h[14:0] == 15'd0);
      if (h[14:10] == 5'd0) begin
         raw = {1'b0, h[9:0]};
         e0  = -8'sd24;
      end else begin
         raw = {1'b1, h[9:0]};
         e0  = $signed({3'b000, h[14:10]}) - 8'sd25;
      end
      lz = 4'd0;
      for (int i = 0; i <= 10; i++) begin
         if (raw[i]) lz = 4'(10 - i);
      end
      u.sig = raw << lz;
      u.exp = e0 - $signed({4'b0000, lz});
      return u;
   endfunction

   front_type      front_in, front_ff;
   lane_stage_type core_in, core_ff;
   lane_stage_type div_pipe [DIV_STEPS+1];
   round_type      rnd_in, rnd_ff;
   logic [15:0]    result_in, result_ff;

   half_type ua, ub, ubr;

   // unpack and catch special operands
   always_comb begin
      ua  = unpack_half(a);
      ubr = unpack_half(b);
      ub  = ubr;
      if (op == OP_SUB) ub.sign = ~ubr.sign;
      front_in.op      = op;
      front_in.ua      = ua;
      front_in.ub      = ub;
      front_in.special = 1'b1;
      front_in.sp_val  = 16'h0000;
      case (op) inside
         OP_RELU: begin
            if (ua.nan) front_in.sp_val = QNAN16;
            else if (!a[15] && !ua.zero) front_in.sp_val = a;
         end
         OP_ADD, OP_SUB: begin
            if (ua.nan || ub.nan) front_in.sp_val = QNAN16;
            else if (ua.inf && ub.inf)
               front_in.sp_val = (ua.sign == ub.sign) ? {ua.sign, INF_MAG} : QNAN16;
            else if (ua.inf) front_in.sp_val = {ua.sign, INF_MAG};
            else if (ub.inf) front_in.sp_val = {ub.sign, INF_MAG};
            else if (ua.zero && ub.zero) front_in.sp_val = {ua.sign & ub.sign, ZERO_MAG};
            else if (ua.zero) front_in.sp_val = {ub.sign, b[14:0]};
            else if (ub.zero) front_in.sp_val = a;
            else front_in.special = 1'b0;
         end
         OP_MUL: begin
            if (ua.nan || ub.nan) front_in.sp_val = QNAN16;
            else if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) front_in.sp_val = QNAN16;
            else if (ua.inf || ub.inf) front_in.sp_val = {ua.sign ^ ub.sign, INF_MAG};
            else if (ua.zero || ub.zero) front_in.sp_val = {ua.sign ^ ub.sign, ZERO_MAG};
            else front_in.special = 1'b0;
         end
         OP_DIV: begin
            if (ua.nan || ub.nan) front_in.sp_val = QNAN16;
            else if (ub.zero)
               front_in.sp_val = ua.zero ? QNAN16 : {ua.sign ^ ub.sign, INF_MAG};
            else if (ua.inf)
               front_in.sp_val = ub.inf ? QNAN16 : {ua.sign ^ ub.sign, INF_MAG};
            else if (ub.inf || ua.zero) front_in.sp_val = {ua.sign ^ ub.sign, ZERO_MAG};
            else front_in.special = 1'b0;
         end
         default: begin
            front_in.sp_val = 16'h0000;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      front_ff <= front_in;
   end

   // align and add, multiply, or set up the divider
   half_type          big, sml;
   logic signed [7:0] dexp;
   logic [4:0]        dsh;
   logic [27:0]       align;
   logic [14:0]       mb, ms, asum;

   always_comb begin
      if ((front_ff.ua.exp > front_ff.ub.exp) ||
          ((front_ff.ua.exp == front_ff.ub.exp) && (front_ff.ua.sig >= front_ff.ub.sig))) begin
         big = front_ff.ua;
         sml = front_ff.ub;
      end else begin
         big = front_ff.ub;
         sml = front_ff.ua;
      end
      dexp  = big.exp - sml.exp;
      dsh   = (dexp > 8'sd28) ? 5'd28 : dexp[4:0];
      align = {sml.sig, 3'b000, 14'd0} >> dsh;
      mb    = {1'b0, big.sig, 3'b000};
      ms    = {1'b0, align[27:14] | {13'd0, |align[13:0]}};
      asum  = (big.sign != sml.sign) ? mb - ms : mb + ms;

      core_in.special = front_ff.special;
      core_in.sp_val  = front_ff.sp_val;
      core_in.is_div  = 1'b0;
      core_in.sign    = front_ff.ua.sign ^ front_ff.ub.sign;
      core_in.exp     = front_ff.ua.exp + front_ff.ub.exp;
      core_in.mag     = {11'd0, front_ff.ua.sig} * {11'd0, front_ff.ub.sig};
      core_in.rem     = {1'b0, front_ff.ua.sig};
      core_in.dvs     = front_ff.ub.sig;
      core_in.quo     = 14'd0;
      case (front_ff.op) inside
         OP_ADD, OP_SUB: begin
            core_in.sign = big.sign;
            core_in.exp  = big.exp - 8'sd3;
            core_in.mag  = {7'd0, asum};
         end
         OP_DIV: begin
            core_in.is_div = !front_ff.special;
            core_in.exp    = front_ff.ua.exp - front_ff.ub.exp - 8'sd14;
         end
         default: begin
            core_in.is_div = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      core_ff <= core_in;
   end

   // divider chain
   assign div_pipe[0] = core_ff;
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      fva_div_stage u_step (
         .clock   (clock),
         .stage_i (div_pipe[k]),
         .stage_o (div_pipe[k+1])
      );
   end

   // leading one, target exponent and shift to the result grid
   lane_stage_type    cs;
   logic [21:0]       mag_c;
   logic [4:0]        lead;
   logic signed [8:0] e_res;
   logic signed [9:0] ne, q_exp, shamt, nsh;
   logic [5:0]        rsh;
   logic [43:0]       wide;
   logic [21:0]       lwide;

   always_comb begin
      cs    = div_pipe[DIV_STEPS];
      mag_c = cs.is_div ? {7'd0, cs.quo, |cs.rem} : cs.mag;
      lead  = 5'd0;
      for (int i = 0; i < 22; i++) begin
         if (mag_c[i]) lead = 5'(i);
      end
      e_res = $signed({4'b0000, lead}) + $signed({cs.exp[7], cs.exp});
      ne    = $signed({e_res[8], e_res}) - 10'sd10;
      q_exp = (ne > -10'sd24) ? ne : -10'sd24;
      shamt = q_exp - $signed({{2{cs.exp[7]}}, cs.exp});
      nsh   = -shamt;
      rsh   = (shamt > 10'sd44) ? 6'd44 : shamt[5:0];
      wide  = {mag_c, 22'd0} >> rsh;
      lwide = mag_c << nsh[3:0];
      rnd_in.special = cs.special;
      rnd_in.sp_val  = cs.sp_val;
      rnd_in.zero    = (mag_c == 22'd0);
      rnd_in.sign    = cs.sign;
      rnd_in.exp     = e_res;
      if (!shamt[9]) begin
         rnd_in.quo    = wide[33:22];
         rnd_in.guard  = wide[21];
         rnd_in.sticky = |wide[20:0];
      end else begin
         rnd_in.quo    = lwide[11:0];
         rnd_in.guard  = 1'b0;
         rnd_in.sticky = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff <= rnd_in;
   end

   // round to nearest even and pack
   logic        inc;
   logic [11:0] qr;

   always_comb begin
      inc = rnd_ff.guard & (rnd_ff.sticky | rnd_ff.quo[0]);
      qr  = rnd_ff.quo + {11'd0, inc};
      if (rnd_ff.special) result_in = rnd_ff.sp_val;
      else if (rnd_ff.zero) result_in = 16'h0000;
      else if (rnd_ff.exp > 9'sd15) result_in = {rnd_ff.sign, INF_MAG};
      else if (rnd_ff.exp < -9'sd14) result_in = {rnd_ff.sign, 4'd0, qr[10:0]};
      else if (qr[11]) begin
         if (rnd_ff.exp == 9'sd15) result_in = {rnd_ff.sign, INF_MAG};
         else result_in = {rnd_ff.sign, 5'(rnd_ff.exp[4:0] + 5'd16), 10'd0};
      end else begin
         result_in = {rnd_ff.sign, 5'(rnd_ff.exp[4:0] + 5'd15), qr[9:0]};
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== design/fva_merge.sv =====
`timescale 1ns / 1ps
module fva_merge import fva_pkg::*; (
   input  logic                 clock,
   input  logic [VEC_W-1:0]     lane_res,
   input  logic [MAX_LANES-1:0] lane_mask,
   output logic [VEC_W-1:0]     result
);

   logic [VEC_W-1:0] result_in, result_ff;

   // zero the lanes past the element count and register the beat
   always_comb begin
      for (int i = 0; i < MAX_LANES; i++) begin
         result_in[HALF_W*i +: HALF_W] = lane_mask[i] ? lane_res[HALF_W*i +: HALF_W]
                                                      : {HALF_W{1'b0}};
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== design/fp16_vector_alu.sv =====
`timescale 1ns / 1ps
// a beat is registered at lane front, core, divider steps, round, result, then merge
// throughput: one beat per cycle; the 14-step divider chain is fully pipelined
// busy is never raised, every start beat is taken
// reset (synchronous, active high) clears the beat pipeline; beats in flight are dropped
// results cannot be stalled and appear for one cycle only
module fp16_vector_alu import fva_pkg::*; #(
   parameter int LANES = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [2:0]       req_type,
   input  logic [VEC_W-1:0] req_a_lanes,
   input  logic [VEC_W-1:0] req_b_lanes,
   input  logic [2:0]       req_valid_lanes,
   output logic             rsp_strobe,
   output logic [VEC_W-1:0] rsp_result_lanes
);

   logic                 accept;
   logic [MAX_LANES-1:0] mask_in;
   logic [MAX_LANES-1:0] mask_ff [LANE_LAT];
   logic [ALU_LAT-1:0]   valid_in, valid_ff;
   logic [VEC_W-1:0]     lane_res;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // lanes that carry real elements for this beat
   always_comb begin
      for (int i = 0; i < MAX_LANES; i++) begin
         mask_in[i] = (i < LANES) && (3'(i) < req_valid_lanes) && (req_type <= OP_RELU);
      end
   end

   // beat tracking
   assign valid_in = {valid_ff[ALU_LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff[0] <= mask_in;
      for (int k = 1; k < LANE_LAT; k++) begin
         mask_ff[k] <= mask_ff[k-1];
      end
   end

   // lane array
   for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
      if (g < LANES) begin : g_on
         fva_lane u_lane (
            .clock  (clock),
            .op     (op_type'(req_type)),
            .a      (req_a_lanes[HALF_W*g +: HALF_W]),
            .b      (req_b_lanes[HALF_W*g +: HALF_W]),
            .result (lane_res[HALF_W*g +: HALF_W])
         );
      end else begin : g_off
         assign lane_res[HALF_W*g +: HALF_W] = {HALF_W{1'b0}};
      end
   end

   fva_merge u_merge (
      .clock     (clock),
      .lane_res  (lane_res),
      .lane_mask (mask_ff[LANE_LAT-1]),
      .result    (rsp_result_lanes)
   );

   assign rsp_strobe = valid_ff[ALU_LAT-1];

   // checks
   a_strobe_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, ALU_LAT))
      else $error("result beat without a start beat");

   a_start_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##ALU_LAT rsp_strobe)
      else $error("start beat produced no result beat");

   a_bad_op_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && ($past(req_type, ALU_LAT) > OP_RELU) |-> rsp_result_lanes == '0)
      else $error("unknown operation gave nonzero lanes");

   a_no_lanes_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && ($past(req_valid_lanes, ALU_LAT) == 3'd0) |-> rsp_result_lanes == '0)
      else $error("empty beat gave nonzero lanes");

endmodule

// ===== sim/fp16_vector_alu_test.sv =====
`timescale 1ns / 1ps
module fp16_vector_alu_test;
   import fva_pkg::*;

   // codes above relu select no operation
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
   localparam logic [15:0] H_POS_INF  = 16'h7C00;
   localparam logic [15:0] H_NEG_INF  = 16'hFC00;
   localparam logic [15:0] H_NEG_ZERO = 16'h8000;
   localparam logic [15:0] H_MAX      = 16'h7BFF;
   localparam logic [15:0] H_MIN_SUB  = 16'h0001;
   localparam logic [15:0] H_ONE      = 16'h3C00;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [2:0]       req_type = '0;
   logic [VEC_W-1:0] req_a_lanes = '0;
   logic [VEC_W-1:0] req_b_lanes = '0;
   logic [2:0]       req_valid_lanes = '0;
   logic             rsp_strobe;
   logic [VEC_W-1:0] rsp_result_lanes;

   logic [VEC_W-1:0] pending_results[$];
   int               error_count = 0;
   int               idle_pct = 0;

   fp16_vector_alu #(.LANES(MAX_LANES)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_a_lanes(req_a_lanes), .req_b_lanes(req_b_lanes),
      .req_valid_lanes(req_valid_lanes), .rsp_strobe(rsp_strobe),
      .rsp_result_lanes(rsp_result_lanes)
   );

   always #5 clock = ~clock;

   // binary16 to double
   function automatic real half_to_real(logic [15:0] h);
      logic [4:0] e;
      real        v;
      e = h[14:10];
      if (e == 5'h1F)
         return $bitstoreal({h[15], 11'h7FF, h[9:0], 42'b0});
      if (e == 5'h00) begin
         v = real'(h[9:0]) / 16777216.0;
         return h[15] ? -v : v;
      end
      return $bitstoreal({h[15], 11'(e - 15 + 1023), h[9:0], 42'b0});
   endfunction

   // double to binary16, round to nearest even
   function automatic logic [15:0] real_to_half(real d);
      logic [63:0] bits, sig, q, r, hb;
      logic [15:0] s;
      int          ex, e, shift;
      bits = $realtobits(d);
      s = {bits[63], 15'b0};
      ex = int'(bits[62:52]);
      if (ex == 'h7FF)
         return (bits[51:0] != 0) ? QNAN16 : (s | {1'b0, INF_MAG});
      if (ex == 0)
         return s;
      e = ex - 1023;
      if (e > 15)
         return s | {1'b0, INF_MAG};
      sig = {12'h001, bits[51:0]};
      shift = (e >= -14) ? 42 : 42 + (-14 - e);
      if (shift >= 64)
         return s;
      q = sig >> shift;
      r = sig & ((64'd1 << shift) - 1);
      hb = 64'd1 << (shift - 1);
      if (r > hb || (r == hb && q[0]))
         q = q + 1;
      if (e < -14)
         return s | q[15:0];
      if (q == 64'd2048) begin
         q = q >> 1;
         e++;
         if (e > 15)
            return s | {1'b0, INF_MAG};
      end
      return s | {1'b0, 5'(e + 15), q[9:0]};
   endfunction

   function automatic logic is_nan(logic [15:0] h);
      return h[14:10] == 5'h1F && h[9:0] != 0;
   endfunction

   // one lane of arithmetic
   function automatic logic [15:0] lane_result(logic [2:0] op, logic [15:0] a, logic [15:0] b);
      real x, y;
      if (op == OP_RELU) begin
         if (is_nan(a)) return QNAN16;
         if (!a[15] && a[14:0] != ZERO_MAG) return a;
         return 16'h0000;
      end
      if (is_nan(a) || is_nan(b)) return QNAN16;
      x = half_to_real(a);
      y = half_to_real(b);
      case (op)
         OP_ADD: return real_to_half(x + y);
         OP_SUB: return real_to_half(x - y);
         OP_MUL: return real_to_half(x * y);
         default: begin
            if (b[14:0] == ZERO_MAG) begin
               if (a[14:0] == ZERO_MAG) return QNAN16;
               return {a[15] ^ b[15], INF_MAG};
            end
            return real_to_half(x / y);
         end
      endcase
   endfunction

   function automatic logic [VEC_W-1:0] vector_result(logic [2:0] op, logic [VEC_W-1:0] a,
                                                      logic [VEC_W-1:0] b, logic [2:0] n);
      logic [VEC_W-1:0] res;
      int               cnt;
      res = '0;
      cnt = (n > MAX_LANES) ? MAX_LANES : n;
      if (op <= OP_RELU)
         for (int i = 0; i < cnt; i++)
            res[16*i +: 16] = lane_result(op, a[16*i +: 16], b[16*i +: 16]);
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // result checking, sampled mid-cycle
   always @(negedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0)
            report_mismatch($sformatf("unexpected result %h", rsp_result_lanes));
         else begin
            for (int i = 0; i < MAX_LANES; i++)
               if (rsp_result_lanes[16*i +: 16] !== pending_results[0][16*i +: 16])
                  report_mismatch($sformatf("lane %0d got %h want %h", i,
                     rsp_result_lanes[16*i +: 16], pending_results[0][16*i +: 16]));
            void'(pending_results.pop_front());
         end
      end
   end

   // one beat, called at a rising edge; returns at the accepting edge
   task automatic send_beat(logic [2:0] op, logic [VEC_W-1:0] a, logic [VEC_W-1:0] b,
                            logic [2:0] n);
      logic taken;
      // each cycle before the beat is idle with the phase's chance
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= op;
      req_a_lanes <= a;
      req_b_lanes <= b;
      req_valid_lanes <= n;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      pending_results.push_back(vector_result(op, a, b, n));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (ALU_LAT + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_half();
      case ($urandom_range(9))
         0: return {1'($urandom_range(1)), 15'h0000};
         1: return {1'($urandom_range(1)), INF_MAG};
         2: return {1'($urandom_range(1)), 5'h1F, 10'($urandom_range(1023, 1))};
         3: return {1'($urandom_range(1)), 5'h00, 10'($urandom)};
         4: return {1'($urandom_range(1)), 5'($urandom_range(30, 28)), 10'($urandom)};
         5: return {1'($urandom_range(1)), 5'($urandom_range(3, 1)), 10'($urandom)};
         6: return {1'($urandom_range(1)), 5'($urandom_range(16, 14)), 10'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [VEC_W-1:0] pick_vector();
      logic [VEC_W-1:0] v;
      for (int i = 0; i < MAX_LANES; i++) v[16*i +: 16] = pick_half();
      return v;
   endfunction

   function automatic logic [VEC_W-1:0] splat(logic [15:0] h);
      return {4{h}};
   endfunction

   task automatic test_special_values();
      send_beat(OP_ADD, {H_NEG_ZERO, 16'h0, H_NEG_ZERO, 16'h0},
                {H_NEG_ZERO, H_NEG_ZERO, 16'h0, 16'h0}, 3'd4);
      send_beat(OP_SUB, {H_POS_INF, H_ONE, H_MAX, H_POS_INF},
                {H_POS_INF, H_ONE, H_NEG_INF, H_NEG_INF}, 3'd4);
      send_beat(OP_ADD, splat(H_MAX), {H_MAX, 16'h6800, 16'h5000, H_NEG_INF}, 3'd4);
      send_beat(OP_MUL, {QNAN16, 16'hFFFF, H_POS_INF, H_MAX},
                {H_ONE, H_ONE, 16'h0, H_MAX}, 3'd4);
      send_beat(OP_MUL, {H_MIN_SUB, 16'h0400, 16'h03FF, 16'h3800},
                {16'h3800, 16'h3800, 16'h3C01, H_MIN_SUB}, 3'd4);
      send_beat(OP_DIV, {16'h0, H_ONE, 16'hBC00, H_POS_INF},
                {16'h0, H_NEG_ZERO, 16'h0, H_POS_INF}, 3'd4);
      send_beat(OP_DIV, {H_MIN_SUB, H_MAX, H_ONE, 16'h4200},
                {H_MAX, H_MIN_SUB, 16'h4200, 16'h4000}, 3'd4);
      send_beat(OP_RELU, {H_NEG_ZERO, 16'h0, 16'hFC01, H_MIN_SUB}, 64'hFFFF_FFFF_FFFF_FFFF,
                3'd4);
      send_beat(OP_RELU, {H_POS_INF, H_NEG_INF, H_MAX, 16'hBC00}, '0, 3'd4);
      send_beat(OP_ADD, {16'h3C01, 16'h3C00, 16'h0001, 16'h8001},
                {16'h1400, 16'h1400, 16'h8001, 16'h8001}, 3'd4);
      // unused op codes, partial and out-of-range lane counts
      send_beat(OP_UNUSED_FIRST, splat(H_ONE), splat(H_ONE), 3'd4);
      send_beat(OP_UNUSED_LAST, splat(H_ONE), splat(H_ONE), 3'd4);
      send_beat(OP_UNUSED_MID, splat(H_ONE), splat(H_ONE), 3'd2);
      send_beat(OP_ADD, splat(H_ONE), splat(H_ONE), 3'd0);
      send_beat(OP_MUL, splat(H_MAX), splat(H_ONE), 3'd1);
      send_beat(OP_SUB, splat(16'h4000), splat(H_ONE), 3'd3);
      send_beat(OP_DIV, splat(H_ONE), splat(16'h4200), 3'd5);
      send_beat(OP_RELU, splat(H_ONE), '0, 3'd7);
      send_beat(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd6);
      wait_drained();
   endtask

   task automatic test_random_beats(int count, int pct);
      logic [2:0] op, n;
      idle_pct = pct;
      for (int k = 0; k < count; k++) begin
         op = ($urandom_range(19) == 0) ? 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST))
                                        : 3'($urandom_range(OP_RELU, OP_ADD));
         n = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(MAX_LANES, 1));
         send_beat(op, pick_vector(), pick_vector(), n);
      end
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_values();
      test_random_beats(450, 0);
      test_random_beats(450, 61);
      test_random_beats(450, 36);
      if (error_count == 0)
         $display("fp16_vector_alu_test: done, clean");
      else
         $display("fp16_vector_alu_test: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      #2ms;
      $display("fp16_vector_alu_test: done, errors");
      $finish;
   end

endmodule
